[design/periodic_timer_table_defines.svh]
// Assertion macros for the timer table, used by the sequencer (ptt_ctrl).
`ifndef PERIODIC_TIMER_TABLE_DEFINES_SVH
`define PERIODIC_TIMER_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked on every clock edge outside reset.
`define PTT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define PTT_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define PTT_ASSERT(label, prop, msg)
`define PTT_ASSERT_RST(label, prop, msg)
`endif

`endif

[design/ptt_pkg.sv]
// Types, constants and helpers of the periodic timer table.
package ptt_pkg;

    localparam int TIMERS      = 32;
    localparam int COUNT_BITS  = 16;
    localparam int MAX_RESULTS = 32;

    localparam int SLOT_AW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int IDX_W   = $clog2(TIMERS + 1);
    localparam int NCNT_W  = $clog2(MAX_RESULTS + 1);

    localparam int OP_W   = 2;
    localparam int SLOT_W = 6;
    localparam int PER_W  = 16;
    localparam int DLY_W  = 16;
    localparam int HND_W  = 8;
    localparam int TAG_W  = 16;
    localparam int KIND_W = 3;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 2'd0,
        OP_REGISTER   = 2'd1,
        OP_SET_PERIOD = 2'd2,
        OP_CANCEL     = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_FIRED      = 3'd0,
        KIND_REGISTERED = 3'd1,
        KIND_FULL       = 3'd2,
        KIND_ACK        = 3'd3,
        KIND_INVALID    = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
        logic [HND_W-1:0]  handler;
        logic [TAG_W-1:0]  tag;
        logic [PER_W-1:0]  period;
    } res_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic [PER_W-1:0]      period;
        logic [HND_W-1:0]      handler;
        logic [TAG_W-1:0]      tag;
    } rec_t;

    typedef struct packed {
        logic [SLOT_AW-1:0] addr;
        logic               we_count;
        logic               we_period;
        logic               we_meta;
        rec_t               data;
    } wr_t;

    // A 16-bit tick value seen through the counter width.
    function automatic logic [COUNT_BITS-1:0] to_count(input logic [PER_W-1:0] ticks);
        return COUNT_BITS'(ticks);
    endfunction

endpackage

[design/ptt_store.sv]
// Slot record memory: counts, periods, handler codes and tags.
module ptt_store
    import ptt_pkg::*;
(
    input  logic               aclk,
    input  wr_t                wr,
    input  logic               rd_en,
    input  logic [SLOT_AW-1:0] rd_addr,
    output rec_t               rd_data
);

    logic [COUNT_BITS-1:0] count_mem   [TIMERS];
    logic [PER_W-1:0]      period_mem  [TIMERS];
    logic [HND_W-1:0]      handler_mem [TIMERS];
    logic [TAG_W-1:0]      tag_mem     [TIMERS];

    always_ff @(posedge aclk) begin
        if (wr.we_count) begin
            count_mem[wr.addr] <= wr.data.count;
        end
        if (wr.we_period) begin
            period_mem[wr.addr] <= wr.data.period;
        end
        if (wr.we_meta) begin
            handler_mem[wr.addr] <= wr.data.handler;
            tag_mem[wr.addr]     <= wr.data.tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data.count   <= count_mem[rd_addr];
            rd_data.period  <= period_mem[rd_addr];
            rd_data.handler <= handler_mem[rd_addr];
            rd_data.tag     <= tag_mem[rd_addr];
        end
    end

endmodule

[design/ptt_ctrl.sv]
// Sequencer of the timer table: slot walk, shared decrement unit, active flags.
`include "periodic_timer_table_defines.svh"

module ptt_ctrl
    import ptt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  op_t                in_op,
    input  logic [SLOT_W-1:0]  in_slot,
    input  logic [PER_W-1:0]   in_period,
    input  logic [DLY_W-1:0]   in_delay,
    input  logic [HND_W-1:0]   in_handler,
    input  logic [TAG_W-1:0]   in_tag,
    output logic               push_valid,
    input  logic               push_ready,
    output res_t               push_res,
    output logic               push_last,
    output wr_t                wr,
    output logic               rd_en,
    output logic [SLOT_AW-1:0] rd_addr,
    input  rec_t               rd_data
);

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                proc_vld_reg, proc_vld_next;
    logic [SLOT_AW-1:0]  proc_idx_reg, proc_idx_next;
    res_t                held_reg, held_next;
    logic                held_vld_reg, held_vld_next;
    logic [NCNT_W-1:0]   fire_cnt_reg, fire_cnt_next;
    logic [TIMERS-1:0]   active_reg, active_next;

    logic [PER_W-1:0]    period_reg;
    logic [DLY_W-1:0]    delay_reg;
    logic [HND_W-1:0]    handler_reg;
    logic [TAG_W-1:0]    tag_reg;

    logic [COUNT_BITS-1:0] dec;
    logic                  dec_zero;
    logic                  fire, capture, stall, walk_done, cur_free, scan_end;

    // Shared unit: one decrement and zero test per cycle.
    assign dec      = rd_data.count - COUNT_BITS'(1);
    assign dec_zero = (dec == '0);

    assign fire      = proc_vld_reg && dec_zero;
    assign capture   = fire && (fire_cnt_reg < NCNT_W'(MAX_RESULTS));
    // A new fire displaces the held one, which must leave first.
    assign stall     = capture && held_vld_reg && !push_ready;
    assign walk_done = (idx_reg == IDX_W'(TIMERS)) && !proc_vld_reg;
    assign cur_free  = !active_reg[idx_reg[SLOT_AW-1:0]];
    assign scan_end  = (idx_reg == IDX_W'(TIMERS - 1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    unique case (in_op)
                        OP_TICK:     state_next = ST_WALK;
                        OP_REGISTER: state_next = ST_SCAN;
                        default:     state_next = ST_FLUSH;
                    endcase
                end
            end
            ST_WALK: begin
                if (walk_done) begin
                    state_next = held_vld_reg ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (cur_free || scan_end) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (push_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        idx_next      = idx_reg;
        proc_vld_next = proc_vld_reg;
        proc_idx_next = proc_idx_reg;
        held_next     = held_reg;
        held_vld_next = held_vld_reg;
        fire_cnt_next = fire_cnt_reg;
        active_next   = active_reg;
        in_ready      = 1'b0;
        wr            = '0;
        rd_en         = 1'b0;
        rd_addr       = idx_reg[SLOT_AW-1:0];
        push_valid    = 1'b0;
        push_last     = 1'b0;
        push_res      = held_reg;

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    unique case (in_op)
                        OP_TICK: begin
                            idx_next      = '0;
                            proc_vld_next = 1'b0;
                            held_vld_next = 1'b0;
                            fire_cnt_next = '0;
                        end
                        OP_REGISTER: begin
                            idx_next = '0;
                        end
                        default: begin
                            held_next      = '0;
                            held_next.slot = in_slot;
                            held_vld_next  = 1'b1;
                            if (in_slot >= SLOT_W'(TIMERS)) begin
                                held_next.kind = KIND_INVALID;
                            end else begin
                                held_next.kind = KIND_ACK;
                                if (in_op == OP_SET_PERIOD) begin
                                    wr.addr        = in_slot[SLOT_AW-1:0];
                                    wr.we_period   = 1'b1;
                                    wr.data.period = in_period;
                                end else begin
                                    active_next[in_slot[SLOT_AW-1:0]] = 1'b0;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_WALK: begin
                push_valid = capture && held_vld_reg;
                if (!stall) begin
                    if (proc_vld_reg) begin
                        wr.addr = proc_idx_reg;
                        if (!dec_zero) begin
                            wr.we_count   = 1'b1;
                            wr.data.count = dec;
                        end else if (rd_data.period != '0) begin
                            wr.we_count   = 1'b1;
                            wr.data.count = to_count(rd_data.period);
                        end else begin
                            active_next[proc_idx_reg] = 1'b0;
                        end
                        if (capture) begin
                            held_next.kind    = KIND_FIRED;
                            held_next.slot    = SLOT_W'(proc_idx_reg);
                            held_next.handler = rd_data.handler;
                            held_next.tag     = rd_data.tag;
                            held_next.period  = rd_data.period;
                            held_vld_next     = 1'b1;
                            fire_cnt_next     = fire_cnt_reg + NCNT_W'(1);
                        end
                    end
                    if (idx_reg != IDX_W'(TIMERS)) begin
                        rd_en         = !active_reg[idx_reg[SLOT_AW-1:0]] ? 1'b0 : 1'b1;
                        proc_vld_next = active_reg[idx_reg[SLOT_AW-1:0]];
                        proc_idx_next = idx_reg[SLOT_AW-1:0];
                        idx_next      = idx_reg + IDX_W'(1);
                    end else begin
                        proc_vld_next = 1'b0;
                    end
                end
            end
            ST_SCAN: begin
                if (cur_free) begin
                    wr.addr         = idx_reg[SLOT_AW-1:0];
                    wr.we_count     = 1'b1;
                    wr.we_period    = 1'b1;
                    wr.we_meta      = 1'b1;
                    wr.data.count   = to_count(delay_reg);
                    wr.data.period  = period_reg;
                    wr.data.handler = handler_reg;
                    wr.data.tag     = tag_reg;
                    active_next[idx_reg[SLOT_AW-1:0]] = 1'b1;
                    held_next       = '0;
                    held_next.kind  = KIND_REGISTERED;
                    held_next.slot  = SLOT_W'(idx_reg);
                    held_vld_next   = 1'b1;
                end else if (scan_end) begin
                    held_next      = '0;
                    held_next.kind = KIND_FULL;
                    held_next.slot = SLOT_W'(TIMERS);
                    held_vld_next  = 1'b1;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_FLUSH: begin
                push_valid = 1'b1;
                push_last  = 1'b1;
                if (push_ready) begin
                    held_vld_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            proc_vld_reg <= 1'b0;
            held_vld_reg <= 1'b0;
            fire_cnt_reg <= '0;
            active_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            proc_vld_reg <= proc_vld_next;
            held_vld_reg <= held_vld_next;
            fire_cnt_reg <= fire_cnt_next;
            active_reg   <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        proc_idx_reg <= proc_idx_next;
        held_reg     <= held_next;
        if (in_valid && in_ready) begin
            period_reg  <= in_period;
            delay_reg   <= in_delay;
            handler_reg <= in_handler;
            tag_reg     <= in_tag;
        end
    end

    `PTT_ASSERT(a_idle_empty, (state_reg == ST_IDLE) |-> !held_vld_reg, "result left behind in idle")
    `PTT_ASSERT(a_fire_cap, fire_cnt_reg <= NCNT_W'(MAX_RESULTS), "fire count beyond cap")
    `PTT_ASSERT(a_stall_hold, (state_reg == ST_WALK && stall) |=> $stable(proc_idx_reg) && proc_vld_reg, "walk moved on during stall")
    `PTT_ASSERT(a_scan_range, (state_reg == ST_SCAN) |-> (idx_reg < IDX_W'(TIMERS)), "scan index out of table")
    `PTT_ASSERT_RST(a_reset_idle, !aresetn |=> (state_reg == ST_IDLE) && !held_vld_reg, "reset did not idle the sequencer")

endmodule

[design/periodic_timer_table.sv]
// Top level of the periodic timer table: stream ports, sequencer, slot memory, output register.
//
//  channel | dir | tdata (low bit up)                                  | tuser        | tlast
//  s_      | in  | slot 6, period 16, delay 16, handler 8, tag 16, pad | operation 2  | -
//  m_      | out | slot_out 6, handler_out 8, tag_out 16, period_out 16| kind 3       | last
//
// A tick is accepted and then walks the slots, one slot per cycle while the output does not stall,
// reading only the active slots from the record memory, then sends the final result if anything
// fired; a walk step in which a waiting beat finds the output register full is held. A register
// scans one slot per cycle; set period and cancel act on acceptance and then send their result.
// s_tready is high only while the sequencer is idle. Reset clears the active flags at once; the
// slot records need no clearing pass.
module periodic_timer_table
    import ptt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // slot, period, delay, handler, tag, zero pad
    input  logic [OP_W-1:0]      s_tuser,  // operation
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // slot_out, handler_out, tag_out, period_out, zero pad
    output logic [KIND_W-1:0]    m_tuser,  // kind
    output logic                 m_tlast
);

    logic               push_valid, push_ready, push_last;
    res_t               push_res;
    wr_t                wr;
    logic               rd_en;
    logic [SLOT_AW-1:0] rd_addr;
    rec_t               rd_data;

    logic out_vld_reg, out_vld_next;
    res_t out_res_reg;
    logic out_last_reg;

    ptt_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (op_t'(s_tuser)),
        .in_slot    (s_tdata[5:0]),
        .in_period  (s_tdata[21:6]),
        .in_delay   (s_tdata[37:22]),
        .in_handler (s_tdata[45:38]),
        .in_tag     (s_tdata[61:46]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_res   (push_res),
        .push_last  (push_last),
        .wr         (wr),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    ptt_store u_store (
        .aclk    (aclk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The output register takes a new beat whenever it is empty or being drained.
    assign push_ready = !out_vld_reg || m_tready;

    always_comb begin
        out_vld_next = out_vld_reg;
        if (push_valid && push_ready) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid && push_ready) begin
            out_res_reg  <= push_res;
            out_last_reg <= push_last;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_res_reg.kind;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_res_reg.period, out_res_reg.tag,
                       out_res_reg.handler, out_res_reg.slot};

endmodule
